// ===== rtl/pct_pkg.sv =====
// Shared types and constants for the presence confirmation table.
package pct_pkg;

    localparam int unsigned TABLES      = 16;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned TBL_W       = 4;
    localparam int unsigned CNT_W       = 16;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [CNT_W-1:0] CNT_ONE       = CNT_W'(1);
    localparam logic [CNT_W-1:0] THR_RESET     = CNT_W'(3);

    typedef enum logic [1:0] {
        KIND_REPORT    = 2'd0,
        KIND_ROUND_END = 2'd1,
        KIND_CHECK     = 2'd2,
        KIND_CLEAR     = 2'd3
    } t_kind;

    typedef struct packed {
        logic               apply;
        t_kind              kind;
        logic [TBL_W-1:0]   tbl;
        logic [KEY_W-1:0]   id_high;
        logic [KEY_W-1:0]   id_low;
        logic [CNT_W-1:0]   thr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic hit;
        logic expire;
    } t_stat;

endpackage

// ===== rtl/pct_if.sv =====
// Channel interfaces for items, results and the threshold write port.
interface pct_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [pct_pkg::TBL_W-1:0]    table_sel;
    logic [pct_pkg::KEY_W-1:0]    id_high;
    logic [pct_pkg::KEY_W-1:0]    id_low;

    modport source (output valid, output kind, output table_sel, output id_high,
                    output id_low, input ready);
    modport sink   (input valid, input kind, input table_sel, input id_high,
                    input id_low, output ready);
endinterface

interface pct_out_if;
    logic valid;
    logic ready;
    logic expired;
    logic table_full;

    modport source (output valid, output expired, output table_full, input ready);
    modport sink   (input valid, input expired, input table_full, output ready);
endinterface

interface pct_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pct_pkg::CNT_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pct_alloc.sv =====
// Lowest free entry picker for new identifiers.
module pct_alloc #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic [ENTRIES-1:0] i_valid_vec,
    output logic [ENTRIES-1:0] o_pick,
    output logic               o_none
);

    logic [ENTRIES-1:0] free_vec;

    assign free_vec = ~i_valid_vec;
    assign o_pick   = free_vec & (~free_vec + ENTRIES'(1));
    assign o_none   = ~|free_vec;

endmodule

// ===== rtl/pct_entry.sv =====
// One table entry: key storage, match compare and per-item update.
module pct_entry (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pct_pkg::t_cmd i_cmd,
    input  logic          i_alloc,
    output pct_pkg::t_stat o_stat
);

    logic                          r_valid;
    logic                          r_seen;
    logic [pct_pkg::KEY_W-1:0]     r_key_high;
    logic [pct_pkg::KEY_W-1:0]     r_key_low;
    logic [pct_pkg::TBL_W-1:0]     r_tbl;
    logic [pct_pkg::CNT_W-1:0]     r_count;

    logic                          n_valid;
    logic                          n_seen;
    logic [pct_pkg::CNT_W-1:0]     n_count;
    logic                          tbl_match;
    logic                          hit;
    logic [pct_pkg::CNT_W-1:0]     bumped;
    logic                          reach;

    assign tbl_match = r_valid && (r_tbl == i_cmd.tbl);
    assign hit       = tbl_match && (r_key_high == i_cmd.id_high) &&
                       (r_key_low == i_cmd.id_low);
    assign bumped    = (r_count == pct_pkg::CNT_MAX) ? r_count : r_count + pct_pkg::CNT_ONE;
    assign reach     = bumped >= i_cmd.thr;

    assign o_stat.valid  = r_valid;
    assign o_stat.hit    = hit;
    assign o_stat.expire = hit && (i_cmd.kind == pct_pkg::KIND_CHECK) && reach;

    always_comb begin
        n_valid = r_valid;
        n_seen  = r_seen;
        n_count = r_count;
        if (i_cmd.apply) begin
            case (i_cmd.kind)
                pct_pkg::KIND_REPORT: begin
                    if (hit && !r_seen) begin
                        n_count = bumped;
                        n_seen  = 1'b1;
                    end
                    if (i_alloc) begin
                        n_valid = 1'b1;
                        n_count = pct_pkg::CNT_ONE;
                        n_seen  = 1'b1;
                    end
                end
                pct_pkg::KIND_ROUND_END: begin
                    if (tbl_match) begin
                        if (!r_seen) begin
                            n_valid = 1'b0;
                        end
                        n_seen = 1'b0;
                    end
                end
                pct_pkg::KIND_CHECK: begin
                    if (hit) begin
                        n_count = bumped;
                        if (reach) begin
                            n_valid = 1'b0;
                            n_seen  = 1'b0;
                        end
                    end
                end
                pct_pkg::KIND_CLEAR: begin
                    if (tbl_match) begin
                        n_valid = 1'b0;
                        n_seen  = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        if (i_cmd.apply && i_alloc) begin
            r_key_high <= i_cmd.id_high;
            r_key_low  <= i_cmd.id_low;
            r_tbl      <= i_cmd.tbl;
        end
    end

endmodule

// ===== rtl/presence_confirm_table_top.sv =====
// Top level of the presence confirmation table.
// An accepted item's result is valid once it has moved from the input register
// to the result register. Throughput: one item per cycle while the result is
// taken; every entry compares and updates in parallel. The input and result
// registers each hold one item, so input stalls only when both are full and
// the result is not taken. Reset empties every entry, sets expiry threshold to 3.
module presence_confirm_table_top #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pct_in_if.sink    i_in,
    pct_cfg_if.sink   i_cfg,
    pct_out_if.source o_out
);

    logic                          r_in_valid;
    pct_pkg::t_kind                r_kind;
    logic [pct_pkg::TBL_W-1:0]     r_tbl;
    logic [pct_pkg::KEY_W-1:0]     r_id_high;
    logic [pct_pkg::KEY_W-1:0]     r_id_low;
    logic [pct_pkg::CNT_W-1:0]     r_thr;
    logic                          r_out_valid;
    logic                          r_expired;
    logic                          r_full;

    logic                          advance;
    logic                          fire;
    logic                          in_range;
    pct_pkg::t_cmd                 cmd;
    pct_pkg::t_stat                stat [ENTRIES];
    logic [ENTRIES-1:0]            valid_vec;
    logic [ENTRIES-1:0]            hit_vec;
    logic [ENTRIES-1:0]            expire_vec;
    logic [ENTRIES-1:0]            pick;
    logic                          none_free;
    logic                          any_hit;
    logic                          insert;
    logic                          n_expired;
    logic                          n_full;

    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign fire        = r_in_valid && advance;
    assign i_cfg.ready = 1'b1;

    assign in_range = 32'(r_tbl) < pct_pkg::TABLES;

    assign cmd.apply   = fire && in_range;
    assign cmd.kind    = r_kind;
    assign cmd.tbl     = r_tbl;
    assign cmd.id_high = r_id_high;
    assign cmd.id_low  = r_id_low;
    assign cmd.thr     = r_thr;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_entry
            pct_entry u_entry (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_alloc (insert && pick[g]),
                .o_stat  (stat[g])
            );
            assign valid_vec[g]  = stat[g].valid;
            assign hit_vec[g]    = stat[g].hit;
            assign expire_vec[g] = stat[g].expire;
        end
    endgenerate

    pct_alloc #(
        .ENTRIES (ENTRIES)
    ) u_alloc (
        .i_valid_vec (valid_vec),
        .o_pick      (pick),
        .o_none      (none_free)
    );

    assign any_hit   = |hit_vec;
    assign insert    = (r_kind == pct_pkg::KIND_REPORT) && !any_hit && !none_free;
    assign n_expired = in_range && (|expire_vec);
    assign n_full    = in_range && (r_kind == pct_pkg::KIND_REPORT) && !any_hit && none_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= pct_pkg::THR_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg.valid) begin
                r_thr <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind    <= pct_pkg::t_kind'(i_in.kind);
            r_tbl     <= i_in.table_sel;
            r_id_high <= i_in.id_high;
            r_id_low  <= i_in.id_low;
        end
        if (fire) begin
            r_expired <= n_expired;
            r_full    <= n_full;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.expired    = r_expired;
    assign o_out.table_full = r_full;

endmodule
